FILE: rtl/core/msc_pkg.sv
// Shared types, constants and saturating helpers for the mass-spring chain step block.
`timescale 1ns / 1ps

package msc_pkg;

    localparam int NODES     = 4;
    localparam int ENTRIES   = 3 * NODES;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int NODE_W    = $clog2(NODES);
    localparam int CFG_IDX_W = 3;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESTORE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 3'd4;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

    typedef struct packed {
        logic               kind;
        logic [1:0]         node_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [16:0]        time_step;
        logic signed [31:0] push_force;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         out_node;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last;
    } t_out_word;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_req;

    // Saturating 32-bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? SAT_MIN : SAT_MAX;
        end
        return s[31:0];
    endfunction

    // Saturating 32-bit subtract
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? SAT_MIN : SAT_MAX;
        end
        return s[31:0];
    endfunction

    // Q16.16 product: floor shift by 16, then saturate
    function automatic logic signed [31:0] fx_sat(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> 16;
        if (q > 64'sh000000007FFFFFFF) begin
            return SAT_MAX;
        end
        if (q < 64'shFFFFFFFF80000000) begin
            return SAT_MIN;
        end
        return q[31:0];
    endfunction

    // Length change of two unsigned 33-bit lengths, saturated
    function automatic logic signed [31:0] sat_chg(input logic [32:0] len,
                                                   input logic [32:0] len0);
        logic signed [33:0] d;
        d = signed'({1'b0, len}) - signed'({1'b0, len0});
        if (d > 34'sh07FFFFFFF) begin
            return SAT_MAX;
        end
        if (d < 34'sh380000000) begin
            return SAT_MIN;
        end
        return d[31:0];
    endfunction

endpackage

FILE: rtl/core/msc_mul.sv
// Shared 32x32 signed multiplier with registered product and Q16.16 rescale.
`timescale 1ns / 1ps

module msc_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod,
    output logic signed [31:0] o_fx
);

    logic signed [63:0] r_prod;
    logic signed [63:0] n_prod;

    // Form the full product
    assign n_prod = 64'(i_a) * 64'(i_b);

    // Register it every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;
    assign o_fx   = msc_pkg::fx_sat(r_prod);

endmodule

FILE: rtl/core/msc_iter.sv
// Iterative unit: 64-bit integer square root (2 bits a cycle) and 48/33 restoring divide.
`timescale 1ns / 1ps

module msc_iter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msc_pkg::t_iter_req i_req,
    input  logic [63:0]        i_radicand,
    input  logic [47:0]        i_num,
    input  logic [32:0]        i_den,
    output logic               o_done,
    output logic [32:0]        o_res
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    msc_pkg::t_iter_op r_op;
    logic [63:0]       r_x, r_r, r_bit;
    logic [47:0]       r_num;
    logic [33:0]       r_rem;
    logic [47:0]       r_quo;
    logic [32:0]       r_den;

    logic [63:0]       w_t;
    logic              w_ge;
    logic [33:0]       w_rem_sh;
    logic              w_rem_ge;
    logic              w_last;

    // One root step and one divide step
    assign w_t      = r_r + r_bit;
    assign w_ge     = (r_x >= w_t);
    assign w_rem_sh = {r_rem[32:0], r_num[47]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_den});
    assign w_last   = (r_op == msc_pkg::OP_SQRT) ? (r_cnt == 6'(msc_pkg::SQRT_STEPS - 1))
                                                 : (r_cnt == 6'(msc_pkg::DIV_STEPS - 1));

    // Sequence the iterations
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 6'd1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Load operands, then advance one step a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_x   <= i_radicand;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (r_op == msc_pkg::OP_SQRT) begin
                if (w_ge) begin
                    r_x <= r_x - w_t;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                r_num <= r_num << 1;
                if (w_rem_ge) begin
                    r_rem <= w_rem_sh - {1'b0, r_den};
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == msc_pkg::OP_SQRT) ? r_r[32:0] : r_quo[32:0];

endmodule

FILE: rtl/core/mass_spring_chain_step_top.sv
// Top level of the mass-spring chain step block: stores, sequencer and output register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word at a time.
//   A load word writes one node's position and rest position and clears its
//   velocity; it produces no output. A load to a node index at or above NODES
//   is dropped.
//   A step word runs one semi-implicit Euler step and emits NODES output words
//   (o_out_valid / i_out_ready / o_out_word), one per node in index order, with
//   last set on the final node. o_in_ready stays low until the step finishes.
//   Each segment costs two square roots and, if its length is nonzero, three
//   divides in the shared iterative unit; all products use one shared multiplier.
//   The output register frees the sequencer as soon as a word is captured; if the
//   receiver stalls, the sequencer holds before loading the next node's word.
//   Configuration writes (i_cfg_we / i_cfg_idx / i_cfg_data) take effect at once
//   and are expected only while the block is idle.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle, drops any
//   pending output word, restores register defaults and clears all velocities.
`timescale 1ns / 1ps

module mass_spring_chain_step_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  msc_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output msc_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    localparam int ENTRIES = msc_pkg::ENTRIES;
    localparam int ADDR_W  = msc_pkg::ADDR_W;
    localparam int NODE_W  = msc_pkg::NODE_W;
    localparam int NODES   = msc_pkg::NODES;

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_INIT    = 24'h000002,
        S_SEG_A   = 24'h000004,
        S_SEG_B   = 24'h000008,
        S_SEG_ACC = 24'h000010,
        S_SQ_GO   = 24'h000020,
        S_SQ_WAIT = 24'h000040,
        S_CHG     = 24'h000080,
        S_DV_GO   = 24'h000100,
        S_DV_WAIT = 24'h000200,
        S_MUL0    = 24'h000400,
        S_MUL1    = 24'h000800,
        S_MUL2    = 24'h001000,
        S_SPR2    = 24'h002000,
        S_RD1     = 24'h004000,
        S_RD2     = 24'h008000,
        S_RD3     = 24'h010000,
        S_PUSH    = 24'h020000,
        S_UP1     = 24'h040000,
        S_UP2     = 24'h080000,
        S_UP3     = 24'h100000,
        S_UP4     = 24'h200000,
        S_UP5     = 24'h400000,
        S_EMIT    = 24'h800000
    } t_state;

    // Configuration registers
    logic [30:0]        r_inv_mass;
    logic signed [31:0] r_gravity;
    logic [30:0]        r_spring;
    logic [30:0]        r_restore;
    logic [30:0]        r_damping;

    // Node stores
    logic signed [31:0] r_pos [ENTRIES];
    logic signed [31:0] r_rst [ENTRIES];
    logic signed [31:0] r_vel [ENTRIES];
    logic signed [31:0] r_frc [ENTRIES];

    // Sequencer state
    t_state             r_state, n_state;
    logic [NODE_W-1:0]  r_i, n_i;
    logic [1:0]         r_k, n_k;
    logic               r_rest, n_rest;
    logic [63:0]        r_sum, n_sum;
    logic signed [31:0] r_ta;
    logic signed [31:0] r_d [3];
    logic [32:0]        r_len, r_len0;
    logic signed [31:0] r_chg, r_u, r_s;
    logic [16:0]        r_dt;
    logic signed [31:0] r_push;
    logic signed [31:0] r_opos [3];

    // Output register
    logic               r_ov, n_ov;
    msc_pkg::t_out_word r_out;

    // Datapath signals
    logic [NODE_W-1:0]  w_node;
    logic [ADDR_W-1:0]  w_ea;
    logic signed [31:0] w_p, w_p0, w_v, w_f, w_sel, w_dnew;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [31:0] w_fx;
    logic               w_f_we;
    logic signed [31:0] w_f_wd;
    logic               w_in_acc;
    logic               w_load_ok;
    logic [ADDR_W-1:0]  w_lbase;
    logic signed [31:0] w_lcoord [3];
    logic               w_emit_go;
    logic               w_seg_last;
    logic signed [31:0] w_dk;
    logic [31:0]        w_abs;
    logic [32:0]        w_iter_res;
    logic               w_iter_done;
    msc_pkg::t_iter_req w_req;
    logic signed [31:0] w_q;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_load_ok  = (32'(i_in_word.node_index) < 32'(NODES));
    assign w_lbase    = ADDR_W'(i_in_word.node_index) * ADDR_W'(3);
    assign w_lcoord[0] = i_in_word.coord_x;
    assign w_lcoord[1] = i_in_word.coord_y;
    assign w_lcoord[2] = i_in_word.coord_z;

    // Pick the node: the far end of a segment in its second half
    assign w_node = (r_state == S_SEG_B || r_state == S_SPR2) ? NODE_W'(r_i + 1'b1) : r_i;
    assign w_ea   = ADDR_W'(w_node) * ADDR_W'(3) + ADDR_W'(r_k);
    assign w_p    = r_pos[w_ea];
    assign w_p0   = r_rst[w_ea];
    assign w_v    = r_vel[w_ea];
    assign w_f    = r_frc[w_ea];
    assign w_sel  = r_rest ? w_p0 : w_p;
    assign w_dnew = msc_pkg::sat_sub(w_sel, r_ta);

    assign w_seg_last = (r_i == NODE_W'(NODES - 2));
    assign w_emit_go  = !r_ov || i_out_ready;

    // Divide operands: magnitude of the segment component, scaled by 2^16
    assign w_dk  = r_d[r_k];
    assign w_abs = w_dk[31] ? 32'(-w_dk) : 32'(w_dk);
    assign w_q   = signed'({15'b0, w_iter_res[16:0]});

    assign w_req.start = (r_state == S_SQ_GO) || (r_state == S_DV_GO);
    assign w_req.op    = (r_state == S_DV_GO) ? msc_pkg::OP_DIV : msc_pkg::OP_SQRT;

    msc_iter u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_radicand (r_sum),
        .i_num      ({w_abs, 16'b0}),
        .i_den      (r_len),
        .o_done     (w_iter_done),
        .o_res      (w_iter_res)
    );

    // Steer the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_SEG_B: begin
                w_mul_a = w_dnew;
                w_mul_b = w_dnew;
            end
            S_MUL0: begin
                w_mul_a = r_u;
                w_mul_b = signed'({1'b0, r_spring});
            end
            S_MUL1: begin
                w_mul_a = w_fx;
                w_mul_b = r_chg;
            end
            S_RD1: begin
                w_mul_a = signed'({1'b0, r_restore});
                w_mul_b = msc_pkg::sat_sub(w_p, w_p0);
            end
            S_RD2: begin
                w_mul_a = signed'({1'b0, r_damping});
                w_mul_b = w_v;
            end
            S_UP1: begin
                w_mul_a = w_f;
                w_mul_b = signed'({1'b0, r_inv_mass});
            end
            S_UP2: begin
                w_mul_a = w_fx;
                w_mul_b = signed'({15'b0, r_dt});
            end
            S_UP4: begin
                w_mul_a = w_v;
                w_mul_b = signed'({15'b0, r_dt});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    msc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod),
        .o_fx   (w_fx)
    );

    // Force accumulation
    always_comb begin
        w_f_we = 1'b1;
        w_f_wd = w_f;
        case (r_state)
            S_MUL2:        w_f_wd = msc_pkg::sat_add(w_f, w_fx);
            S_SPR2:        w_f_wd = msc_pkg::sat_sub(w_f, r_s);
            S_RD2, S_RD3:  w_f_wd = msc_pkg::sat_sub(w_f, w_fx);
            S_PUSH:        w_f_wd = msc_pkg::sat_add(w_f, r_push);
            default:       w_f_we = 1'b0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_rest  = r_rest;
        n_sum   = r_sum;
        n_ov    = r_ov;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_in_word.kind == msc_pkg::KIND_STEP) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_i     = '0;
                n_k     = '0;
                n_rest  = 1'b0;
                n_sum   = '0;
                n_state = S_SEG_A;
            end
            S_SEG_A: n_state = S_SEG_B;
            S_SEG_B: n_state = S_SEG_ACC;
            S_SEG_ACC: begin
                n_sum = r_sum + unsigned'(w_prod);
                if (r_k == 2'd2) begin
                    n_state = S_SQ_GO;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SEG_A;
                end
            end
            S_SQ_GO: n_state = S_SQ_WAIT;
            S_SQ_WAIT: begin
                if (w_iter_done) begin
                    n_k = '0;
                    if (!r_rest) begin
                        n_rest  = 1'b1;
                        n_sum   = '0;
                        n_state = S_SEG_A;
                    end else begin
                        n_state = S_CHG;
                    end
                end
            end
            S_CHG: begin
                if (r_len == '0) begin
                    n_k    = '0;
                    n_rest = 1'b0;
                    n_sum  = '0;
                    if (w_seg_last) begin
                        n_i     = '0;
                        n_state = S_RD1;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SEG_A;
                    end
                end else begin
                    n_k     = '0;
                    n_state = S_DV_GO;
                end
            end
            S_DV_GO: n_state = S_DV_WAIT;
            S_DV_WAIT: begin
                if (w_iter_done) begin
                    n_state = S_MUL0;
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SPR2;
            S_SPR2: begin
                if (r_k == 2'd2) begin
                    n_k    = '0;
                    n_rest = 1'b0;
                    n_sum  = '0;
                    if (w_seg_last) begin
                        n_i     = '0;
                        n_state = S_RD1;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_SEG_A;
                    end
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_DV_GO;
                end
            end
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_RD3;
            S_RD3: begin
                if (r_k == 2'd2) begin
                    n_k = '0;
                    if (r_i == NODE_W'(NODES - 1)) begin
                        n_i     = '0;
                        n_state = S_PUSH;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_RD1;
                    end
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_RD1;
                end
            end
            S_PUSH: n_state = S_UP1;
            S_UP1:  n_state = S_UP2;
            S_UP2:  n_state = S_UP3;
            S_UP3:  n_state = S_UP4;
            S_UP4:  n_state = S_UP5;
            S_UP5: begin
                if (r_k == 2'd2) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_UP1;
                end
            end
            S_EMIT: begin
                if (w_emit_go) begin
                    n_ov = 1'b1;
                    if (r_i == NODE_W'(NODES - 1)) begin
                        n_i     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_UP1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_i        <= '0;
            r_k        <= '0;
            r_rest     <= 1'b0;
            r_ov       <= 1'b0;
            r_inv_mass <= 31'd65536;
            r_gravity  <= '0;
            r_spring   <= '0;
            r_restore  <= '0;
            r_damping  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_rest  <= n_rest;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    msc_pkg::REG_INV_MASS: r_inv_mass <= i_cfg_data[30:0];
                    msc_pkg::REG_GRAVITY:  r_gravity  <= signed'(i_cfg_data);
                    msc_pkg::REG_SPRING:   r_spring   <= i_cfg_data[30:0];
                    msc_pkg::REG_RESTORE:  r_restore  <= i_cfg_data[30:0];
                    msc_pkg::REG_DAMPING:  r_damping  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
        end
    end

    // Velocity store: cleared by reset and by a load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_vel[e] <= '0;
            end
        end else if (r_state == S_IDLE) begin
            if (w_in_acc && i_in_word.kind == msc_pkg::KIND_LOAD && w_load_ok) begin
                for (int c = 0; c < 3; c++) begin
                    r_vel[w_lbase + ADDR_W'(c)] <= '0;
                end
            end
        end else if (r_state == S_UP3) begin
            r_vel[w_ea] <= msc_pkg::sat_add(w_v, w_fx);
        end
    end

    // Payload registers and stores
    always_ff @(posedge i_clk) begin
        // Load one node
        if (w_in_acc && i_in_word.kind == msc_pkg::KIND_LOAD && w_load_ok) begin
            for (int c = 0; c < 3; c++) begin
                r_pos[w_lbase + ADDR_W'(c)] <= w_lcoord[c];
                r_rst[w_lbase + ADDR_W'(c)] <= w_lcoord[c];
            end
        end
        // Latch step operands
        if (w_in_acc && i_in_word.kind == msc_pkg::KIND_STEP) begin
            r_dt   <= i_in_word.time_step;
            r_push <= i_in_word.push_force;
        end
        // Seed forces with gravity weight
        if (r_state == S_INIT) begin
            for (int j = 0; j < NODES; j++) begin
                r_frc[ADDR_W'(j * 3)]     <= '0;
                r_frc[ADDR_W'(j * 3 + 1)] <= r_gravity;
                r_frc[ADDR_W'(j * 3 + 2)] <= '0;
            end
        end else if (w_f_we) begin
            r_frc[w_ea] <= w_f_wd;
        end
        if (r_state == S_SEG_A) begin
            r_ta <= w_sel;
        end
        if (r_state == S_SEG_B && !r_rest) begin
            r_d[r_k] <= w_dnew;
        end
        if (r_state == S_SQ_WAIT && w_iter_done) begin
            if (r_rest) begin
                r_len0 <= w_iter_res;
            end else begin
                r_len <= w_iter_res;
            end
        end
        if (r_state == S_CHG) begin
            r_chg <= msc_pkg::sat_chg(r_len, r_len0);
        end
        if (r_state == S_DV_WAIT && w_iter_done) begin
            r_u <= w_dk[31] ? -w_q : w_q;
        end
        if (r_state == S_MUL2) begin
            r_s <= w_fx;
        end
        // New position
        if (r_state == S_UP5) begin
            r_pos[w_ea]   <= msc_pkg::sat_add(w_p, w_fx);
            r_opos[r_k]   <= msc_pkg::sat_add(w_p, w_fx);
        end
        // Capture the output word
        if (r_state == S_EMIT && w_emit_go) begin
            r_out.out_node <= 2'(r_i);
            r_out.pos_x    <= r_opos[0];
            r_out.pos_y    <= r_opos[1];
            r_out.pos_z    <= r_opos[2];
            r_out.last     <= (r_i == NODE_W'(NODES - 1));
        end
        r_sum <= n_sum;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_iter_done |-> (r_state == S_SQ_WAIT || r_state == S_DV_WAIT))
        else $error("iterative unit finished while sequencer was not waiting");

    a_last_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.last) |-> (r_out.out_node == 2'(NODES - 1)))
        else $error("last flag on a node other than the final one");

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.kind == msc_pkg::KIND_STEP) |=> (r_state == S_INIT))
        else $error("accepted step word did not start the sequencer");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_word.kind == msc_pkg::KIND_LOAD) |=> o_in_ready)
        else $error("load word left the block busy");
`endif

endmodule
